// ===== rtl/tmps_pkg.sv =====
// Shared types and constants for the triangle minimum path sum unit.
package tmps_pkg;

  localparam int SUM_W       = 24;
  localparam int ROW_COUNT_W = 9;

  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};

  // Per-beat control carried from the issue stage to the update stage.
  typedef struct packed {
    logic first_row;  // row zero: no parent
    logic has_up;     // parent directly above exists
    logic has_left;   // parent up-left exists
    logic last_row;   // beat belongs to the final row
    logic row_end;    // last beat of its row
  } tmps_ctl_t;

endpackage

// ===== rtl/triangle_min_path_sum_unit.sv =====
// Top level of the triangle minimum path sum unit.
//
//   channel   signals                              direction
//   input     in_valid_i / in_ready_o, cell_value_i  in
//   result    out_valid_o / out_ready_i, min_total_o out
//   config    cfg_we_i, cfg_wdata_i (row_count)      in, no handshake
//
// One beat per cycle sustained while the update stage is not stalled. A beat is
// issued at its accept edge (counters advance, row memory read at its column)
// and updated when it leaves the update stage registers (add-min, write back),
// so the result is loaded into the output register as the final beat leaves
// that stage. A read of the column written in the same cycle is bypassed.
// Reset clears control state only; row sums need no clearing pass since every
// entry is written before it is read.
// A held result stalls the update stage only when the next final beat reaches
// it; input then holds until the result is taken.
module triangle_min_path_sum_unit #(
  parameter int MAX_ROWS   = 256,
  parameter int VALUE_BITS = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic signed [VALUE_BITS-1:0]          cell_value_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic signed [tmps_pkg::SUM_W-1:0]     min_total_o,
  input  logic                                  cfg_we_i,
  input  logic [tmps_pkg::ROW_COUNT_W-1:0]      cfg_wdata_i
);
  import tmps_pkg::*;

  localparam int IDX_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CMP_W = (IDX_W + 1 > ROW_COUNT_W + 1) ? IDX_W + 1 : ROW_COUNT_W + 1;

  // Configuration.
  logic [ROW_COUNT_W-1:0] row_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_count_q <= ROW_COUNT_W'(1);
    end else if (cfg_we_i) begin
      row_count_q <= cfg_wdata_i;
    end
  end

  // Issue stage: row/column counters.
  logic [IDX_W-1:0] row_q, row_d;
  logic [IDX_W-1:0] col_q, col_d;
  logic             in_fire;
  tmps_ctl_t        ctl;

  // Update stage registers.
  logic             s1_valid_q, s1_valid_d;
  tmps_ctl_t        s1_ctl_q;
  logic [IDX_W-1:0] s1_addr_q;
  logic signed [SUM_W-1:0] s1_value_q;
  logic             s1_end;
  logic             s1_fire;

  // Bypass of a same-cycle write to the column being read.
  logic                    byp_q;
  logic signed [SUM_W-1:0] byp_data_q;

  logic signed [SUM_W-1:0] mem_rdata;
  logic signed [SUM_W-1:0] old_here;
  logic signed [SUM_W-1:0] fresh;
  logic signed [SUM_W-1:0] new_min;

  // Output register.
  logic                    out_valid_q, out_valid_d;
  logic signed [SUM_W-1:0] out_data_q;

  always_comb begin
    ctl.first_row = (row_q == '0);
    ctl.has_up    = (col_q < row_q);
    ctl.has_left  = (col_q != '0);
    ctl.row_end   = (col_q >= row_q);
    // Zero rows counts as one; above the capacity saturates.
    ctl.last_row  = (row_count_q == '0)
                 || ((CMP_W'(row_q) + CMP_W'(1)) >= CMP_W'(row_count_q))
                 || (row_q == IDX_W'(MAX_ROWS - 1));
  end

  assign s1_end     = s1_ctl_q.row_end && s1_ctl_q.last_row;
  assign s1_fire    = s1_valid_q && (!s1_end || !out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_fire;
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    row_d = row_q;
    col_d = col_q;
    if (in_fire) begin
      if (ctl.row_end) begin
        col_d = '0;
        row_d = ctl.last_row ? '0 : row_q + IDX_W'(1);
      end else begin
        col_d = col_q + IDX_W'(1);
      end
    end
    s1_valid_d = in_fire ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q      <= '0;
      col_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      row_q      <= row_d;
      col_q      <= col_d;
      s1_valid_q <= s1_valid_d;
    end
  end

  // Stage payload; advance only on accept.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_ctl_q   <= ctl;
      s1_addr_q  <= col_q;
      s1_value_q <= SUM_W'(cell_value_i);
      byp_q      <= s1_fire && (s1_addr_q == col_q);
      byp_data_q <= fresh;
    end
  end

  tmps_row_mem #(
    .DEPTH  (MAX_ROWS),
    .ADDR_W (IDX_W)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (s1_fire),
    .waddr_i (s1_addr_q),
    .wdata_i (fresh),
    .re_i    (in_fire),
    .raddr_i (col_q),
    .rdata_o (mem_rdata)
  );

  assign old_here = byp_q ? byp_data_q : mem_rdata;

  tmps_update u_update (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (s1_fire),
    .ctl_i      (s1_ctl_q),
    .value_i    (s1_value_q),
    .old_here_i (old_here),
    .fresh_o    (fresh),
    .min_o      (new_min)
  );

  // Load the result on the final beat; drop it once taken.
  always_comb begin
    out_valid_d = out_valid_q;
    if (s1_fire && s1_end) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && s1_end) begin
      out_data_q <= new_min;
    end
  end

  assign out_valid_o = out_valid_q;
  assign min_total_o = out_data_q;

endmodule

// ===== rtl/tmps_row_mem.sv =====
// Single-port-write, single-port-read row memory with registered read data.
module tmps_row_mem #(
  parameter int DEPTH  = 256,
  parameter int ADDR_W = 8
) (
  input  logic                            clk_i,
  input  logic                            we_i,
  input  logic [ADDR_W-1:0]               waddr_i,
  input  logic signed [tmps_pkg::SUM_W-1:0] wdata_i,
  input  logic                            re_i,
  input  logic [ADDR_W-1:0]               raddr_i,
  output logic signed [tmps_pkg::SUM_W-1:0] rdata_o
);
  import tmps_pkg::*;

  logic signed [SUM_W-1:0] mem_q [DEPTH];
  logic signed [SUM_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read-first: a same-cycle write is forwarded by the caller.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/tmps_update.sv =====
// Update stage: add-min of parent sums, left-parent hold and running minimum.
module tmps_update (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              fire_i,
  input  tmps_pkg::tmps_ctl_t               ctl_i,
  input  logic signed [tmps_pkg::SUM_W-1:0] value_i,
  input  logic signed [tmps_pkg::SUM_W-1:0] old_here_i,
  output logic signed [tmps_pkg::SUM_W-1:0] fresh_o,
  output logic signed [tmps_pkg::SUM_W-1:0] min_o
);
  import tmps_pkg::*;

  logic signed [SUM_W-1:0] left_q, left_d;
  logic signed [SUM_W-1:0] run_min_q, run_min_d;
  logic signed [SUM_W-1:0] best;
  logic signed [SUM_W-1:0] fresh;
  logic signed [SUM_W-1:0] new_min;
  logic                    tri_end;

  always_comb begin
    if (ctl_i.has_up && ctl_i.has_left) begin
      best = (old_here_i < left_q) ? old_here_i : left_q;
    end else if (ctl_i.has_up) begin
      best = old_here_i;
    end else begin
      best = left_q;
    end
    fresh   = ctl_i.first_row ? value_i : value_i + best;
    new_min = (ctl_i.last_row && (fresh < run_min_q)) ? fresh : run_min_q;
    tri_end = ctl_i.row_end && ctl_i.last_row;

    left_d    = left_q;
    run_min_d = run_min_q;
    if (fire_i) begin
      left_d    = tri_end ? '0 : old_here_i;
      run_min_d = tri_end ? SUM_MAX : new_min;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q    <= '0;
      run_min_q <= SUM_MAX;
    end else begin
      left_q    <= left_d;
      run_min_q <= run_min_d;
    end
  end

  assign fresh_o = fresh;
  assign min_o   = new_min;

endmodule

// ===== rtl/tmps_checker.sv =====
// Port-level checker for the triangle minimum path sum unit, with its bind.
module tmps_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_ready_o,
  input logic                              out_valid_o,
  input logic                              out_ready_i,
  input logic signed [tmps_pkg::SUM_W-1:0] min_total_o
);

  // Hold a stalled result beat.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(min_total_o))
    else $error("result beat changed while stalled");

  // With nothing held at the output, the input side never backs up.
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty output register");

  // A fresh result follows an accepted input beat, registered in the update stage and then in the output register.
  a_out_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o, 2))
    else $error("result without a matching input beat");

endmodule

bind triangle_min_path_sum_unit tmps_checker u_tmps_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .min_total_o (min_total_o)
);
